@@ hw/rtl/cau_pkg.sv @@
// Shared types, constants and the output saturation function of the complex arithmetic unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = PROD_W + 2;
    localparam int MAG_W      = PROD_W + 1;
    localparam int CMP_W      = PROD_W + DATA_WIDTH + FRAC_BITS + 1;

    localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'd1 << (DATA_WIDTH - 1));
    localparam logic [MAG_W-1:0] OVF_MAG = MAG_W'(64'd1 << DATA_WIDTH);

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_SUB,
        CMD_MUL,
        CMD_DIV
    } cmd_t;

    // One result part in sign-magnitude form, with the divider's working state.
    typedef struct packed {
        logic                  neg;
        logic [MAG_W-1:0]      mag;
        logic [PROD_W-1:0]     rem;
        logic [DATA_WIDTH-1:0] bits;
        logic                  ovf;
    } part_t;

    // One request as it travels down the pipeline.
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              dz;
        logic [PROD_W-1:0] den;
        part_t             re;
        part_t             im;
    } item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data;
        logic                  sat;
    } packed_t;

    // Clip a sign-magnitude value to the signed output range.
    function automatic packed_t pack_part(input logic neg, input logic [MAG_W-1:0] mag);
        packed_t          r;
        logic [MAG_W-1:0] tmp;
        r.sat = 1'b0;
        tmp   = MAG_W'(0) - mag;
        if (neg) begin
            if (mag > NEG_LIM) begin
                r.data = {1'b1, {(DATA_WIDTH-1){1'b0}}};
                r.sat  = 1'b1;
            end else begin
                r.data = tmp[DATA_WIDTH-1:0];
            end
        end else begin
            if (mag > POS_LIM) begin
                r.data = {1'b0, {(DATA_WIDTH-1){1'b1}}};
                r.sat  = 1'b1;
            end else begin
                r.data = mag[DATA_WIDTH-1:0];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cau_front.sv @@
// Front stages of the complex arithmetic unit: products, sums and divider setup.
// Depends on cau_pkg.
`default_nettype none

module cau_front import cau_pkg::*; (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire logic [1:0]                   in_cmd,
    input  wire logic signed [DATA_WIDTH-1:0] a_re,
    input  wire logic signed [DATA_WIDTH-1:0] a_im,
    input  wire logic signed [DATA_WIDTH-1:0] b_re,
    input  wire logic signed [DATA_WIDTH-1:0] b_im,
    output item_t                             item
);

    // Stage one registers
    logic                     v1_reg;
    cmd_t                     cmd1_reg;
    logic signed [DATA_WIDTH-1:0] are1_reg, aim1_reg, bre1_reg, bim1_reg;
    logic signed [PROD_W-1:0] ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;

    // Stage two registers
    logic                     v2_reg;
    cmd_t                     cmd2_reg;
    logic signed [SUM_W-1:0]  re2_reg, im2_reg;
    logic signed [SUM_W-1:0]  re2_next, im2_next;
    logic [PROD_W-1:0]        den2_reg, den2_next;

    // Stage three register
    item_t item_reg, item_next;

    // Turn a signed sum into a sign-magnitude part, or set up a division.
    function automatic part_t make_part(input logic signed [SUM_W-1:0] x, input cmd_t cmd,
                                        input logic [PROD_W-1:0] den);
        logic [SUM_W-1:0] absx;
        logic [MAG_W-1:0] m;
        part_t            p;
        absx   = x[SUM_W-1] ? (SUM_W'(0) - $unsigned(x)) : $unsigned(x);
        m      = absx[MAG_W-1:0];
        p.neg  = x[SUM_W-1];
        p.mag  = m;
        p.rem  = '0;
        p.bits = '0;
        p.ovf  = 1'b0;
        case (cmd)
            CMD_MUL: begin
                p.mag = m >> FRAC_BITS;
            end
            CMD_DIV: begin
                p.mag  = '0;
                p.rem  = PROD_W'(m >> (DATA_WIDTH - FRAC_BITS));
                p.bits = DATA_WIDTH'(m << FRAC_BITS);
                p.ovf  = (CMP_W'(m) << FRAC_BITS) >= (CMP_W'(den) << DATA_WIDTH);
            end
            default: begin
            end
        endcase
        return p;
    endfunction

    // Stage one: register operands and form all six products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
        end
        if (adv) begin
            cmd1_reg <= cmd_t'(in_cmd);
            are1_reg <= a_re;
            aim1_reg <= a_im;
            bre1_reg <= b_re;
            bim1_reg <= b_im;
            ac_reg   <= PROD_W'(a_re * b_re);
            bd_reg   <= PROD_W'(a_im * b_im);
            ad_reg   <= PROD_W'(a_re * b_im);
            bc_reg   <= PROD_W'(a_im * b_re);
            cc_reg   <= PROD_W'(b_re * b_re);
            dd_reg   <= PROD_W'(b_im * b_im);
        end
    end

    // Stage two: sums and differences for the selected command.
    always_comb begin
        den2_next = PROD_W'($unsigned(cc_reg)) + PROD_W'($unsigned(dd_reg));
        case (cmd1_reg)
            CMD_ADD: begin
                re2_next = SUM_W'(are1_reg) + SUM_W'(bre1_reg);
                im2_next = SUM_W'(aim1_reg) + SUM_W'(bim1_reg);
            end
            CMD_SUB: begin
                re2_next = SUM_W'(are1_reg) - SUM_W'(bre1_reg);
                im2_next = SUM_W'(aim1_reg) - SUM_W'(bim1_reg);
            end
            CMD_MUL: begin
                re2_next = SUM_W'(ac_reg) - SUM_W'(bd_reg);
                im2_next = SUM_W'(ad_reg) + SUM_W'(bc_reg);
            end
            default: begin
                re2_next = SUM_W'(ac_reg) + SUM_W'(bd_reg);
                im2_next = SUM_W'(bc_reg) - SUM_W'(ad_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            cmd2_reg <= cmd1_reg;
            re2_reg  <= re2_next;
            im2_reg  <= im2_next;
            den2_reg <= den2_next;
        end
    end

    // Stage three: magnitudes, overflow check and divider setup.
    always_comb begin
        item_next.valid  = v2_reg;
        item_next.den    = den2_reg;
        item_next.dz     = (cmd2_reg == CMD_DIV) && (den2_reg == '0);
        item_next.is_div = (cmd2_reg == CMD_DIV) && (den2_reg != '0);
        item_next.re     = make_part(re2_reg, cmd2_reg, den2_reg);
        item_next.im     = make_part(im2_reg, cmd2_reg, den2_reg);
        if (item_next.dz) begin
            item_next.re = '0;
            item_next.im = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (adv) begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cau_div_step.sv @@
// One restoring division step for both result parts, with its pipeline register.
// Depends on cau_pkg.
`default_nettype none

module cau_div_step import cau_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic adv,
    input  item_t     d,
    output item_t     q
);

    item_t item_reg, item_next;

    // Shift in one dividend bit, subtract the divisor when it fits.
    function automatic part_t step(input part_t p, input logic [PROD_W-1:0] den);
        logic [PROD_W:0] r_sh;
        logic            ge;
        part_t           r;
        r_sh   = {p.rem, p.bits[DATA_WIDTH-1]};
        ge     = r_sh >= {1'b0, den};
        r      = p;
        r.rem  = ge ? PROD_W'(r_sh - {1'b0, den}) : r_sh[PROD_W-1:0];
        r.bits = {p.bits[DATA_WIDTH-2:0], 1'b0};
        r.mag  = {p.mag[MAG_W-2:0], ge};
        return r;
    endfunction

    always_comb begin
        item_next = d;
        if (d.is_div) begin
            item_next.re = step(d.re, d.den);
            item_next.im = step(d.im, d.den);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (adv) begin
            item_reg <= item_next;
        end
    end

    assign q = item_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cau_divider.sv @@
// Pipelined divider: a chain of one-bit division steps, one quotient bit per stage.
// Depends on cau_pkg and cau_div_step.
`default_nettype none

module cau_divider import cau_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic adv,
    input  item_t     d,
    output item_t     q
);

    item_t chain [DATA_WIDTH+1];

    assign chain[0] = d;

    // One stage for each quotient bit, most significant first.
    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
        cau_div_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .d       (chain[i]),
            .q       (chain[i+1])
        );
    end

    assign q = chain[DATA_WIDTH];

endmodule

`default_nettype wire

@@ hw/rtl/complex_arithmetic_unit_core.sv @@
// Complex arithmetic unit, top level: handshake, pipeline control and output clipping.
// Depends on cau_pkg, cau_front and cau_divider.
//
// Each request on the s_ channel carries a command (add, subtract, multiply,
// divide) and two complex operands in signed Q8.8. Each request yields exactly
// one result on the m_ channel: real and imaginary parts in signed Q8.8,
// clipped to range with m_saturated set, and m_div_by_zero set for a divide
// by zero, in which case both parts are zero.
// From acceptance to m_valid a request passes three front stages
// (products, sums, divider setup), one stage per quotient bit of the
// 16-stage divider, and the output register. Every command takes the same
// path, so results leave in request order.
// Throughput is one request per cycle unless frozen; the divider is fully pipelined.
// When the receiver holds m_ready low with a result waiting, the whole
// pipeline freezes and s_ready drops; nothing is lost or repeated. Bubbles
// in the pipeline keep moving while the output register is empty.
// Synchronous active-low reset clears all valid bits; the block is ready
// to accept a request once reset is released.
`default_nettype none

module complex_arithmetic_unit_core import cau_pkg::*; (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_command,
    input  wire logic signed [DATA_WIDTH-1:0] s_a_real,
    input  wire logic signed [DATA_WIDTH-1:0] s_a_imag,
    input  wire logic signed [DATA_WIDTH-1:0] s_b_real,
    input  wire logic signed [DATA_WIDTH-1:0] s_b_imag,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_res_real,
    output logic signed [DATA_WIDTH-1:0]      m_res_imag,
    output logic                              m_saturated,
    output logic                              m_div_by_zero
);

    logic    adv;
    item_t   front_item, div_item;
    packed_t re_pk, im_pk;
    logic    [MAG_W-1:0] re_mag, im_mag;

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] re_reg, im_reg;
    logic                  sat_reg, dz_reg;

    // The pipeline moves whenever the output register is free or being read.
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    cau_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_valid),
        .in_cmd   (s_command),
        .a_re     (s_a_real),
        .a_im     (s_a_imag),
        .b_re     (s_b_real),
        .b_im     (s_b_imag),
        .item     (front_item)
    );

    cau_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .d       (front_item),
        .q       (div_item)
    );

    // A quotient flagged by the overflow check is forced past the clip limit.
    always_comb begin
        re_mag = (div_item.is_div && div_item.re.ovf) ? OVF_MAG : div_item.re.mag;
        im_mag = (div_item.is_div && div_item.im.ovf) ? OVF_MAG : div_item.im.mag;
        re_pk  = pack_part(div_item.re.neg, re_mag);
        im_pk  = pack_part(div_item.im.neg, im_mag);
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= div_item.valid;
        end
        if (adv) begin
            re_reg  <= re_pk.data;
            im_reg  <= im_pk.data;
            sat_reg <= re_pk.sat | im_pk.sat;
            dz_reg  <= div_item.dz;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_res_real    = re_reg;
    assign m_res_imag    = im_reg;
    assign m_saturated   = sat_reg;
    assign m_div_by_zero = dz_reg;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the complex arithmetic unit: directed corner
// requests, random traffic under three idling mixes and a long output stall.
// Depends on cau_pkg and complex_arithmetic_unit_core.
`timescale 1ns / 1ps

module testbench;
    import cau_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] re;
        logic signed [DATA_WIDTH-1:0] im;
        logic                         sat;
        logic                         dz;
    } cplx_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_command = CMD_ADD;
    logic signed [DATA_WIDTH-1:0] s_a_real = '0;
    logic signed [DATA_WIDTH-1:0] s_a_imag = '0;
    logic signed [DATA_WIDTH-1:0] s_b_real = '0;
    logic signed [DATA_WIDTH-1:0] s_b_imag = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DATA_WIDTH-1:0] m_res_real;
    logic signed [DATA_WIDTH-1:0] m_res_imag;
    logic m_saturated;
    logic m_div_by_zero;

    cplx_result_t pending_results[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int error_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int sat_count = 0;
    int dz_count = 0;
    int quiet_cycles = 0;

    complex_arithmetic_unit_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_a_real(s_a_real), .s_a_imag(s_a_imag),
        .s_b_real(s_b_real), .s_b_imag(s_b_imag),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_res_real(m_res_real), .m_res_imag(m_res_imag),
        .m_saturated(m_saturated), .m_div_by_zero(m_div_by_zero)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Clip a wide signed value to the output range and note any clipping.
    function automatic logic [DATA_WIDTH-1:0] clip_part(input longint v, inout logic sat);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
        lo = -(longint'(1) <<< (DATA_WIDTH - 1));
        if (v > hi) begin
            sat = 1'b1;
            return hi[DATA_WIDTH-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[DATA_WIDTH-1:0];
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    // Exact complex arithmetic; signed division truncates toward zero.
    function automatic cplx_result_t complex_result(input cmd_t cmd,
            input logic signed [DATA_WIDTH-1:0] ar, input logic signed [DATA_WIDTH-1:0] ai,
            input logic signed [DATA_WIDTH-1:0] br, input logic signed [DATA_WIDTH-1:0] bi);
        cplx_result_t r;
        longint a, b, c, d, re, im, den;
        a = ar;
        b = ai;
        c = br;
        d = bi;
        re = 0;
        im = 0;
        r.sat = 1'b0;
        r.dz = 1'b0;
        case (cmd)
            CMD_ADD: begin
                re = a + c;
                im = b + d;
            end
            CMD_SUB: begin
                re = a - c;
                im = b - d;
            end
            CMD_MUL: begin
                re = (a * c - b * d) / (longint'(1) <<< FRAC_BITS);
                im = (a * d + b * c) / (longint'(1) <<< FRAC_BITS);
            end
            default: begin
                den = c * c + d * d;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    re = ((a * c + b * d) * (longint'(1) <<< FRAC_BITS)) / den;
                    im = ((b * c - a * d) * (longint'(1) <<< FRAC_BITS)) / den;
                end
            end
        endcase
        r.re = clip_part(re, r.sat);
        r.im = clip_part(im, r.sat);
        return r;
    endfunction

    // Offer one request and wait until it is accepted.
    task automatic send_request(input cmd_t cmd,
            input logic [DATA_WIDTH-1:0] ar, input logic [DATA_WIDTH-1:0] ai,
            input logic [DATA_WIDTH-1:0] br, input logic [DATA_WIDTH-1:0] bi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_a_real <= ar;
        s_a_imag <= ai;
        s_b_real <= br;
        s_b_imag <= bi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(complex_result(cmd, ar, ai, br, bi));
        sent_count++;
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [DATA_WIDTH-1:0] random_operand();
        case ($urandom_range(5))
            0: return DATA_WIDTH'($urandom_range(2047)) - DATA_WIDTH'(1024);
            1: begin
                case ($urandom_range(4))
                    0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
                    1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
                    2: return '0;
                    3: return '1;
                    default: return DATA_WIDTH'(1 << FRAC_BITS);
                endcase
            end
            2: return DATA_WIDTH'($urandom_range(255)) - DATA_WIDTH'(128);
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    // Corner requests: range ends, every command, zero divisor, clipping.
    task automatic test_directed();
        logic [DATA_WIDTH-1:0] mx, mn, one;
        mx = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        mn = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        one = DATA_WIDTH'(1 << FRAC_BITS);
        send_request(CMD_ADD, mx, mn, mx, mn);
        send_request(CMD_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
        send_request(CMD_SUB, mn, mx, mx, mn);
        send_request(CMD_SUB, mx, mx, mx, mx);
        send_request(CMD_SUB, '0, '0, mn, mn);
        send_request(CMD_MUL, mx, mx, mx, mx);
        send_request(CMD_MUL, mn, mn, mn, mn);
        send_request(CMD_MUL, mn, '0, mn, '0);
        send_request(CMD_MUL, one, one, one, 16'hff00);
        send_request(CMD_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
        send_request(CMD_DIV, one, one, '0, '0);
        send_request(CMD_DIV, '0, '0, '0, '0);
        send_request(CMD_DIV, mx, mx, 16'h0001, '0);
        send_request(CMD_DIV, mn, mn, 16'h0001, 16'h0001);
        send_request(CMD_DIV, one, '0, one, '0);
        send_request(CMD_DIV, 16'hff00, one, 16'h0300, 16'hfd00);
        send_request(CMD_DIV, mn, '0, mn, '0);
        send_request(CMD_DIV, mn, mn, mn, mn);
        send_request(CMD_DIV, 16'h0001, 16'hffff, mx, mn);
        send_request(CMD_DIV, '1, '1, '1, '1);
        // The sender stops here until every result is back.
        wait_for_drain();
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        cmd_t cmd;
        logic [DATA_WIDTH-1:0] br, bi;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            cmd = cmd_t'($urandom_range(3));
            br = random_operand();
            bi = random_operand();
            if (cmd == CMD_DIV && $urandom_range(15) == 0) begin
                br = '0;
                bi = '0;
            end
            send_request(cmd, random_operand(), random_operand(), br, bi);
        end
        wait_for_drain();
    endtask

    // The receiver stalls long enough for the pipeline to fill and block input.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 150;
        repeat (60) send_request(cmd_t'($urandom_range(3)), DATA_WIDTH'($urandom),
            DATA_WIDTH'($urandom), DATA_WIDTH'($urandom), DATA_WIDTH'($urandom));
        wait_for_drain();
    endtask

    // Receiver readiness, including the long hold-off.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare every delivered result with the oldest outstanding one.
    always @(posedge aclk) begin
        cplx_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none outstanding: re %h im %h", $time,
                    m_res_real, m_res_imag);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (want.sat) sat_count++;
                if (want.dz) dz_count++;
                if (m_res_real !== want.re)
                    $display("%0t: res_real expected %h actual %h", $time, want.re, m_res_real);
                if (m_res_imag !== want.im)
                    $display("%0t: res_imag expected %h actual %h", $time, want.im, m_res_imag);
                if (m_saturated !== want.sat)
                    $display("%0t: saturated expected %b actual %b", $time, want.sat,
                        m_saturated);
                if (m_div_by_zero !== want.dz)
                    $display("%0t: div_by_zero expected %b actual %b", $time, want.dz,
                        m_div_by_zero);
                if (m_res_real !== want.re || m_res_imag !== want.im ||
                        m_saturated !== want.sat || m_div_by_zero !== want.dz)
                    error_count++;
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(450, 8, 68);
        test_random(450, 68, 8);
        test_random(450, 0, 0);
        test_output_stall();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) error_count++;
        $display("Sent %0d requests, checked %0d results (%0d clipped, %0d zero divisor).",
            sent_count, checked_count, sat_count, dz_count);
        $display("Covered all four commands under three idling mixes and a long stall.");
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

@@ complex_arithmetic_unit_core.f @@
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_div_step.sv
hw/rtl/cau_divider.sv
hw/rtl/complex_arithmetic_unit_core.sv
dv/testbench.sv
